// ----- sv/pss_pkg.sv -----
// Shared types, constants and command encodings for the pen stroke smoother.
`default_nettype none
package pss_pkg;

  localparam int POS_WIDTH      = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int PRES_W         = 16;
  localparam int TILT_W         = 16;
  localparam int COEF_W         = 17;
  localparam int DZ_W           = 23;
  localparam int LAG_W          = 24;
  localparam int REQ_W          = 2;
  localparam int NUM_LANES      = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd2;

  localparam logic [COEF_W-1:0] ALPHA_RESET = 17'd32768;

  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CATCH   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;

  typedef logic [2:0] lane_t;
  localparam lane_t LANE_X  = 3'd0;
  localparam lane_t LANE_Y  = 3'd1;
  localparam lane_t LANE_P  = 3'd2;
  localparam lane_t LANE_TX = 3'd3;
  localparam lane_t LANE_TY = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic [PRES_W-1:0]         pressure;
    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
    logic [COEF_W-1:0]         catch_t;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] out_x;
    logic signed [POS_WIDTH-1:0] out_y;
    logic [PRES_W-1:0]         out_pressure;
    logic signed [TILT_W-1:0]  out_tilt_x;
    logic signed [TILT_W-1:0]  out_tilt_y;
    logic [LAG_W-1:0]          lag_distance;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CATCH_X,
    ST_CATCH_Y,
    ST_PASS,
    ST_DZ_SQX,
    ST_DZ_SQY,
    ST_DZ_WAIT,
    ST_DZ_ROOT_INIT,
    ST_DZ_ROOT,
    ST_DZ_CHECK,
    ST_DZ_DIV,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_P,
    ST_MUL_TX,
    ST_MUL_TY,
    ST_LAG_SQX,
    ST_LAG_SQY,
    ST_LAG_WAIT,
    ST_LAG_ROOT_INIT,
    ST_LAG_ROOT,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PASS,
    OP_MUL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_SMOOTH,
    WB_CATCH,
    WB_SQ_FIRST,
    WB_SQ_NEXT
  } wb_t;

  typedef enum logic [1:0] {
    COEF_A,
    COEF_AP,
    COEF_K,
    COEF_T
  } coef_sel_t;

  typedef struct packed {
    op_t       op;
    lane_t     lane;
    coef_sel_t coef;
    wb_t       wb;
  } cmd_t;

  typedef struct packed {
    logic catch_req;
    logic restart_req;
    logic enabled;
    logic started;
    logic dz_on;
    logic root_last;
    logic div_last;
    logic d_gt_dz;
  } status_t;

endpackage
`default_nettype wire

// ----- sv/pen_stroke_smoother_top.sv -----
// Top level of the pen stroke smoother: controller and datapath.
//
// Usage: pen samples and catch-up queries enter on the in_ channel (valid and
// ready); each produces exactly one result on the out_ channel. The cfg_ port
// writes smoothing enable, position weight and dead-zone radius, one register
// per cycle with cfg_we; the user must write only while no item is in flight,
// as the block does not enforce it. One item is worked on at a time: no new
// item is taken until the last result is taken. The lag distance is formed
// by a 25-step square root; with the dead zone active, a second root comes
// first, and a 17-step restoring divide too when the point is outside the
// radius. All products share one multiplier.
// The result is held in an output register until out_ready; in_ready returns
// in the cycle after the result is taken.
// Reset (rst_n low at a clock edge) clears both points and the stroke flag,
// disables smoothing, sets the weight to one half and the radius to zero.
`default_nettype none
module pen_stroke_smoother_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pss_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pss_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pss_pkg::cmd_t    cmd;
  pss_pkg::status_t status;
  logic             in_accept;

  assign in_accept = in_valid && in_ready;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pss_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_item   (in_data),
    .cmd       (cmd),
    .out_item  (out_data),
    .status    (status)
  );

endmodule
`default_nettype wire

// ----- sv/pss_datapath.sv -----
// Datapath: state registers, shared multiplier, square root and divide units.
`default_nettype none
module pss_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_accept,
  input  wire pss_pkg::in_item_t               in_item,
  input  wire pss_pkg::cmd_t                   cmd,
  output pss_pkg::out_item_t                   out_item,
  output pss_pkg::status_t                     status
);

  localparam int P    = pss_pkg::POS_WIDTH;
  localparam int CF   = pss_pkg::COEF_FRAC_BITS;
  localparam int LW   = P + 1;
  localparam int MAGW = P;
  localparam int CW   = CF + 1;
  localparam int MBW  = (MAGW > CW) ? MAGW : CW;
  localparam int PW   = MAGW + MBW;
  localparam int SUMW = 2 * MAGW + 1;
  localparam int NSQ  = (SUMW + 1) / 2;
  localparam int BW   = 2 * NSQ;
  localparam int DW   = NSQ;
  localparam int NW   = DW + CF;
  localparam int QN   = CW;
  localparam int SCW  = $clog2(NSQ + 1);
  localparam int DCW  = $clog2(QN + 1);
  localparam int LAGW = pss_pkg::LAG_W;

  localparam logic [CW-1:0]   ONE     = {1'b1, {CF{1'b0}}};
  localparam logic [PW-1:0]   HALF    = PW'(1) << (CF - 1);
  localparam logic [LAGW-1:0] LAG_MAX = {LAGW{1'b1}};

  logic                        en_r;
  logic [pss_pkg::COEF_W-1:0]  alpha_r;
  logic [pss_pkg::DZ_W-1:0]    dz_r;
  logic [pss_pkg::REQ_W-1:0]   req_r;
  logic [pss_pkg::COEF_W-1:0]  t_r;
  logic                        started_r;
  logic signed [LW-1:0]        smooth_r [pss_pkg::NUM_LANES];
  logic signed [LW-1:0]        raw_r    [pss_pkg::NUM_LANES];
  logic signed [LW-1:0]        cx_r;
  logic signed [LW-1:0]        cy_r;
  logic [PW-1:0]               prod_r;
  logic                        neg_r;
  logic signed [LW-1:0]        base_r;
  pss_pkg::wb_t                wb_r;
  pss_pkg::lane_t              lane_r;
  logic [SUMW-1:0]             sum_r;
  logic [BW-1:0]               rem_r;
  logic [BW-1:0]               res_r;
  logic [BW-1:0]               bit_r;
  logic [SCW-1:0]              scnt_r;
  logic [QN-1:0]               num_r;
  logic [DW:0]                 drem_r;
  logic [QN-1:0]               q_r;
  logic [DCW-1:0]              dcnt_r;
  pss_pkg::out_item_t          out_r;

  logic [CW-1:0]        a_c;
  logic [CW-1:0]        ap_c;
  logic [CW-1:0]        t_c;
  logic [CW-1:0]        coef_c;
  logic signed [LW-1:0] diff_c;
  logic [MAGW-1:0]      mag_c;
  logic [MBW-1:0]       mul_b_c;
  logic [PW-1:0]        prod_c;
  logic [MAGW-1:0]      p_c;
  logic signed [LW-1:0] new_c;
  logic [BW-1:0]        try_c;
  logic                 sq_ge_c;
  logic [DW-1:0]        d_c;
  logic [DW:0]          dt_c;
  logic                 dge_c;
  logic [NW-1:0]        numw_c;
  logic [LAGW-1:0]      lag_c;

  always_comb begin
    a_c  = (CW'(alpha_r) > ONE) ? ONE : CW'(alpha_r);
    t_c  = (CW'(t_r) > ONE) ? ONE : CW'(t_r);
    ap_c = CW'(({1'b0, ONE} + {1'b0, a_c}) >> 1);
    case (cmd.coef)
      pss_pkg::COEF_A:  coef_c = a_c;
      pss_pkg::COEF_AP: coef_c = ap_c;
      pss_pkg::COEF_K:  coef_c = q_r;
      default:          coef_c = t_c;
    endcase
    diff_c  = LW'(raw_r[cmd.lane] - smooth_r[cmd.lane]);
    mag_c   = diff_c[LW-1] ? MAGW'(-diff_c) : MAGW'(diff_c);
    mul_b_c = (cmd.wb == pss_pkg::WB_SQ_FIRST || cmd.wb == pss_pkg::WB_SQ_NEXT)
              ? MBW'(mag_c) : MBW'(coef_c);
    prod_c  = {{MBW{1'b0}}, mag_c} * {{MAGW{1'b0}}, mul_b_c};
    p_c     = MAGW'((prod_r + HALF) >> CF);
    new_c   = neg_r ? LW'(base_r - $signed({1'b0, p_c}))
                    : LW'(base_r + $signed({1'b0, p_c}));
    try_c   = res_r + bit_r;
    sq_ge_c = rem_r >= try_c;
    d_c     = res_r[DW-1:0];
    dt_c    = {drem_r[DW-1:0], num_r[QN-1]};
    dge_c   = dt_c >= {1'b0, d_c};
    numw_c  = (NW'(d_c - DW'(dz_r)) << CF) + NW'(d_c >> 1);
    if (!en_r || !started_r) begin
      lag_c = '0;
    end else if (d_c > DW'(LAG_MAX)) begin
      lag_c = LAG_MAX;
    end else begin
      lag_c = LAGW'(d_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      alpha_r <= pss_pkg::ALPHA_RESET;
      dz_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pss_pkg::CFG_SMOOTH_EN: en_r    <= cfg_wdata[0];
        pss_pkg::CFG_ALPHA:     alpha_r <= cfg_wdata[pss_pkg::COEF_W-1:0];
        pss_pkg::CFG_DEAD_ZONE: dz_r    <= cfg_wdata[pss_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      for (int i = 0; i < pss_pkg::NUM_LANES; i++) begin
        smooth_r[i] <= '0;
        raw_r[i]    <= '0;
      end
    end else begin
      if (in_accept && in_item.req_type < pss_pkg::REQ_CATCH) begin
        raw_r[pss_pkg::LANE_X]  <= LW'(in_item.pos_x);
        raw_r[pss_pkg::LANE_Y]  <= LW'(in_item.pos_y);
        raw_r[pss_pkg::LANE_P]  <= LW'({1'b0, in_item.pressure});
        raw_r[pss_pkg::LANE_TX] <= LW'(in_item.tilt_x);
        raw_r[pss_pkg::LANE_TY] <= LW'(in_item.tilt_y);
      end
      if (cmd.op == pss_pkg::OP_PASS) begin
        started_r <= 1'b1;
        for (int i = 0; i < pss_pkg::NUM_LANES; i++) begin
          smooth_r[i] <= raw_r[i];
        end
      end
      if (wb_r == pss_pkg::WB_SMOOTH) begin
        smooth_r[lane_r] <= new_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= pss_pkg::WB_NONE;
    end else begin
      wb_r <= (cmd.op == pss_pkg::OP_MUL) ? cmd.wb : pss_pkg::WB_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_item.req_type;
      t_r   <= in_item.catch_t;
    end
    if (cmd.op == pss_pkg::OP_MUL) begin
      prod_r <= prod_c;
      neg_r  <= diff_c[LW-1];
      base_r <= smooth_r[cmd.lane];
      lane_r <= cmd.lane;
    end
    case (wb_r)
      pss_pkg::WB_CATCH: begin
        if (lane_r == pss_pkg::LANE_X) begin
          cx_r <= new_c;
        end else begin
          cy_r <= new_c;
        end
      end
      pss_pkg::WB_SQ_FIRST: sum_r <= SUMW'(prod_r);
      pss_pkg::WB_SQ_NEXT:  sum_r <= sum_r + SUMW'(prod_r);
      default: ;
    endcase
    case (cmd.op)
      pss_pkg::OP_SQRT_INIT: begin
        rem_r  <= BW'(sum_r);
        res_r  <= '0;
        bit_r  <= BW'(1) << (BW - 2);
        scnt_r <= SCW'(NSQ);
      end
      pss_pkg::OP_SQRT_STEP: begin
        if (sq_ge_c) begin
          rem_r <= rem_r - try_c;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        scnt_r <= scnt_r - SCW'(1);
      end
      pss_pkg::OP_DIV_INIT: begin
        drem_r <= (DW + 1)'(numw_c >> QN);
        num_r  <= numw_c[QN-1:0];
        q_r    <= '0;
        dcnt_r <= DCW'(QN);
      end
      pss_pkg::OP_DIV_STEP: begin
        drem_r <= dge_c ? (dt_c - {1'b0, d_c}) : dt_c;
        num_r  <= num_r << 1;
        q_r    <= {q_r[QN-2:0], dge_c};
        dcnt_r <= dcnt_r - DCW'(1);
      end
      pss_pkg::OP_FINISH: begin
        if (req_r >= pss_pkg::REQ_CATCH) begin
          out_r.out_x <= P'(cx_r);
          out_r.out_y <= P'(cy_r);
          out_r.out_pressure <= pss_pkg::PRES_W'(raw_r[pss_pkg::LANE_P]);
          out_r.out_tilt_x   <= pss_pkg::TILT_W'(raw_r[pss_pkg::LANE_TX]);
          out_r.out_tilt_y   <= pss_pkg::TILT_W'(raw_r[pss_pkg::LANE_TY]);
        end else begin
          out_r.out_x <= P'(smooth_r[pss_pkg::LANE_X]);
          out_r.out_y <= P'(smooth_r[pss_pkg::LANE_Y]);
          out_r.out_pressure <= pss_pkg::PRES_W'(smooth_r[pss_pkg::LANE_P]);
          out_r.out_tilt_x   <= pss_pkg::TILT_W'(smooth_r[pss_pkg::LANE_TX]);
          out_r.out_tilt_y   <= pss_pkg::TILT_W'(smooth_r[pss_pkg::LANE_TY]);
        end
        out_r.lag_distance <= lag_c;
      end
      default: ;
    endcase
  end

  assign out_item = out_r;

  always_comb begin
    status.catch_req   = req_r >= pss_pkg::REQ_CATCH;
    status.restart_req = req_r == pss_pkg::REQ_RESTART;
    status.enabled     = en_r;
    status.started     = started_r;
    status.dz_on       = dz_r != '0;
    status.root_last   = scnt_r == SCW'(1);
    status.div_last    = dcnt_r == DCW'(1);
    status.d_gt_dz     = d_c > DW'(dz_r);
  end

endmodule
`default_nettype wire

// ----- sv/pss_ctrl.sv -----
// Controller: sequences the datapath through each item and drives the handshakes.
`default_nettype none
module pss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  input  wire pss_pkg::status_t  status,
  output logic                   in_ready,
  output logic                   out_valid,
  output pss_pkg::cmd_t          cmd
);

  pss_pkg::state_t state_r;
  pss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::ST_IDLE:     if (in_valid) state_nxt = pss_pkg::ST_DISPATCH;
      pss_pkg::ST_DISPATCH: begin
        if (status.catch_req) begin
          state_nxt = pss_pkg::ST_CATCH_X;
        end else if (!status.enabled || status.restart_req || !status.started) begin
          state_nxt = pss_pkg::ST_PASS;
        end else if (status.dz_on) begin
          state_nxt = pss_pkg::ST_DZ_SQX;
        end else begin
          state_nxt = pss_pkg::ST_MUL_X;
        end
      end
      pss_pkg::ST_CATCH_X:      state_nxt = pss_pkg::ST_CATCH_Y;
      pss_pkg::ST_CATCH_Y:      state_nxt = pss_pkg::ST_LAG_SQX;
      pss_pkg::ST_PASS:         state_nxt = pss_pkg::ST_LAG_SQX;
      pss_pkg::ST_DZ_SQX:       state_nxt = pss_pkg::ST_DZ_SQY;
      pss_pkg::ST_DZ_SQY:       state_nxt = pss_pkg::ST_DZ_WAIT;
      pss_pkg::ST_DZ_WAIT:      state_nxt = pss_pkg::ST_DZ_ROOT_INIT;
      pss_pkg::ST_DZ_ROOT_INIT: state_nxt = pss_pkg::ST_DZ_ROOT;
      pss_pkg::ST_DZ_ROOT:      if (status.root_last) state_nxt = pss_pkg::ST_DZ_CHECK;
      pss_pkg::ST_DZ_CHECK: begin
        state_nxt = status.d_gt_dz ? pss_pkg::ST_DZ_DIV : pss_pkg::ST_MUL_P;
      end
      pss_pkg::ST_DZ_DIV:        if (status.div_last) state_nxt = pss_pkg::ST_MUL_X;
      pss_pkg::ST_MUL_X:         state_nxt = pss_pkg::ST_MUL_Y;
      pss_pkg::ST_MUL_Y:         state_nxt = pss_pkg::ST_MUL_P;
      pss_pkg::ST_MUL_P:         state_nxt = pss_pkg::ST_MUL_TX;
      pss_pkg::ST_MUL_TX:        state_nxt = pss_pkg::ST_MUL_TY;
      pss_pkg::ST_MUL_TY:        state_nxt = pss_pkg::ST_LAG_SQX;
      pss_pkg::ST_LAG_SQX:       state_nxt = pss_pkg::ST_LAG_SQY;
      pss_pkg::ST_LAG_SQY:       state_nxt = pss_pkg::ST_LAG_WAIT;
      pss_pkg::ST_LAG_WAIT:      state_nxt = pss_pkg::ST_LAG_ROOT_INIT;
      pss_pkg::ST_LAG_ROOT_INIT: state_nxt = pss_pkg::ST_LAG_ROOT;
      pss_pkg::ST_LAG_ROOT:      if (status.root_last) state_nxt = pss_pkg::ST_FINISH;
      pss_pkg::ST_FINISH:        state_nxt = pss_pkg::ST_OUT;
      pss_pkg::ST_OUT:           if (out_ready) state_nxt = pss_pkg::ST_IDLE;
      default:                   state_nxt = pss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state_r == pss_pkg::ST_IDLE;
    out_valid = state_r == pss_pkg::ST_OUT;
    cmd.op    = pss_pkg::OP_NONE;
    cmd.lane  = pss_pkg::LANE_X;
    cmd.coef  = pss_pkg::COEF_A;
    cmd.wb    = pss_pkg::WB_NONE;
    unique case (state_r)
      pss_pkg::ST_CATCH_X: begin
        cmd.op = pss_pkg::OP_MUL; cmd.coef = pss_pkg::COEF_T; cmd.wb = pss_pkg::WB_CATCH;
      end
      pss_pkg::ST_CATCH_Y: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_Y;
        cmd.coef = pss_pkg::COEF_T; cmd.wb = pss_pkg::WB_CATCH;
      end
      pss_pkg::ST_PASS: cmd.op = pss_pkg::OP_PASS;
      pss_pkg::ST_DZ_SQX, pss_pkg::ST_LAG_SQX: begin
        cmd.op = pss_pkg::OP_MUL; cmd.wb = pss_pkg::WB_SQ_FIRST;
      end
      pss_pkg::ST_DZ_SQY, pss_pkg::ST_LAG_SQY: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_Y; cmd.wb = pss_pkg::WB_SQ_NEXT;
      end
      pss_pkg::ST_DZ_ROOT_INIT, pss_pkg::ST_LAG_ROOT_INIT: cmd.op = pss_pkg::OP_SQRT_INIT;
      pss_pkg::ST_DZ_ROOT, pss_pkg::ST_LAG_ROOT:           cmd.op = pss_pkg::OP_SQRT_STEP;
      pss_pkg::ST_DZ_CHECK: cmd.op = pss_pkg::OP_DIV_INIT;
      pss_pkg::ST_DZ_DIV:   cmd.op = pss_pkg::OP_DIV_STEP;
      pss_pkg::ST_MUL_X: begin
        cmd.op = pss_pkg::OP_MUL; cmd.wb = pss_pkg::WB_SMOOTH;
        cmd.coef = status.dz_on ? pss_pkg::COEF_K : pss_pkg::COEF_A;
      end
      pss_pkg::ST_MUL_Y: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_Y; cmd.wb = pss_pkg::WB_SMOOTH;
        cmd.coef = status.dz_on ? pss_pkg::COEF_K : pss_pkg::COEF_A;
      end
      pss_pkg::ST_MUL_P: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_P;
        cmd.coef = pss_pkg::COEF_AP; cmd.wb = pss_pkg::WB_SMOOTH;
      end
      pss_pkg::ST_MUL_TX: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_TX;
        cmd.coef = pss_pkg::COEF_AP; cmd.wb = pss_pkg::WB_SMOOTH;
      end
      pss_pkg::ST_MUL_TY: begin
        cmd.op = pss_pkg::OP_MUL; cmd.lane = pss_pkg::LANE_TY;
        cmd.coef = pss_pkg::COEF_AP; cmd.wb = pss_pkg::WB_SMOOTH;
      end
      pss_pkg::ST_FINISH: cmd.op = pss_pkg::OP_FINISH;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the pen stroke smoother: directed and random pen items checked against a model.
module tb_top;

  localparam longint ONE = 64'd65536;
  localparam longint HALF = 64'd32768;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pss_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pss_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  pen_stroke_smoother_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  bit smooth_on;
  longint pos_weight;
  longint dz_radius;
  longint sm_x, sm_y, sm_p, sm_tx, sm_ty;
  longint rw_x, rw_y, rw_p, rw_tx, rw_ty;
  bit in_stroke;

  pss_pkg::out_item_t expected_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint scale_toward(longint diff, longint coef);
    longint p;
    p = (magnitude(diff) * coef + HALF) >>> 16;
    return diff < 0 ? -p : p;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint point_gap(longint dx, longint dy);
    longint ax, ay, m;
    int sh;
    ax = magnitude(dx);
    ay = magnitude(dy);
    m = ax > ay ? ax : ay;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 31)) sh++;
    ax = ax >> sh;
    ay = ay >> sh;
    return int_sqrt(ax * ax + ay * ay) << sh;
  endfunction

  function automatic pss_pkg::out_item_t smooth_item(pss_pkg::in_item_t it);
    pss_pkg::out_item_t r;
    longint x, y, pr, tx, ty, t, a, ap, dx, dy, d, k, lag;
    longint ox, oy, op, otx, oty;
    x = longint'(it.pos_x);
    y = longint'(it.pos_y);
    pr = longint'({1'b0, it.pressure});
    tx = longint'(it.tilt_x);
    ty = longint'(it.tilt_y);
    t = it.catch_t > ONE ? ONE : longint'(it.catch_t);
    a = pos_weight > ONE ? ONE : pos_weight;
    ap = (ONE + a) >> 1;
    if (it.req_type >= pss_pkg::REQ_CATCH) begin
      ox = sm_x + scale_toward(rw_x - sm_x, t);
      oy = sm_y + scale_toward(rw_y - sm_y, t);
      op = rw_p; otx = rw_tx; oty = rw_ty;
    end else begin
      if (!smooth_on || it.req_type == pss_pkg::REQ_RESTART || !in_stroke) begin
        sm_x = x; sm_y = y; sm_p = pr; sm_tx = tx; sm_ty = ty;
        in_stroke = 1;
      end else begin
        if (dz_radius != 0) begin
          dx = x - sm_x;
          dy = y - sm_y;
          d = point_gap(dx, dy);
          if (d > dz_radius) begin
            k = (((d - dz_radius) << 16) + (d >> 1)) / d;
            sm_x += scale_toward(dx, k);
            sm_y += scale_toward(dy, k);
          end
        end else begin
          sm_x += scale_toward(x - sm_x, a);
          sm_y += scale_toward(y - sm_y, a);
        end
        sm_p += scale_toward(pr - sm_p, ap);
        sm_tx += scale_toward(tx - sm_tx, ap);
        sm_ty += scale_toward(ty - sm_ty, ap);
      end
      rw_x = x; rw_y = y; rw_p = pr; rw_tx = tx; rw_ty = ty;
      ox = sm_x; oy = sm_y; op = sm_p; otx = sm_tx; oty = sm_ty;
    end
    if (!smooth_on || !in_stroke) begin
      lag = 0;
    end else begin
      lag = point_gap(rw_x - sm_x, rw_y - sm_y);
      if (lag > 16777215) lag = 16777215;
    end
    r.out_x = ox[pss_pkg::POS_WIDTH-1:0];
    r.out_y = oy[pss_pkg::POS_WIDTH-1:0];
    r.out_pressure = op[pss_pkg::PRES_W-1:0];
    r.out_tilt_x = otx[pss_pkg::TILT_W-1:0];
    r.out_tilt_y = oty[pss_pkg::TILT_W-1:0];
    r.lag_distance = lag[pss_pkg::LAG_W-1:0];
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    pss_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_data);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
    end
  end

  task automatic send_item(pss_pkg::in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(smooth_item(it));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [pss_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[pss_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pss_pkg::CFG_SMOOTH_EN) smooth_on = val[0];
    else if (idx == pss_pkg::CFG_ALPHA) pos_weight = val & 32'h1FFFF;
    else if (idx == pss_pkg::CFG_DEAD_ZONE) dz_radius = val & 32'h7FFFFF;
  endtask

  function automatic pss_pkg::in_item_t make_item(logic [pss_pkg::REQ_W-1:0] req, int span);
    pss_pkg::in_item_t it;
    it.req_type = req;
    if (span == 0) begin
      it.pos_x = pss_pkg::POS_WIDTH'($urandom());
      it.pos_y = pss_pkg::POS_WIDTH'($urandom());
    end else begin
      it.pos_x = pss_pkg::POS_WIDTH'(int'($urandom_range(2 * span)) - span);
      it.pos_y = pss_pkg::POS_WIDTH'(int'($urandom_range(2 * span)) - span);
    end
    it.pressure = pss_pkg::PRES_W'($urandom());
    it.tilt_x = pss_pkg::TILT_W'($urandom());
    it.tilt_y = pss_pkg::TILT_W'($urandom());
    it.catch_t = ($urandom_range(9) == 0)
                 ? pss_pkg::COEF_W'(32'h1FFFF - $urandom_range(65535))
                 : pss_pkg::COEF_W'($urandom_range(65536));
    return it;
  endfunction

  function automatic pss_pkg::in_item_t fixed_item(logic [pss_pkg::REQ_W-1:0] req, int x,
                                                   int y, int p, int tx, int ty, int t);
    pss_pkg::in_item_t it;
    it.req_type = req;
    it.pos_x = pss_pkg::POS_WIDTH'(x); it.pos_y = pss_pkg::POS_WIDTH'(y);
    it.pressure = pss_pkg::PRES_W'(p);
    it.tilt_x = pss_pkg::TILT_W'(tx); it.tilt_y = pss_pkg::TILT_W'(ty);
    it.catch_t = pss_pkg::COEF_W'(t);
    return it;
  endfunction

  task automatic test_directed;
    send_item(fixed_item(pss_pkg::REQ_CATCH, 100, 100, 5, 5, 5, 65536));
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 8388607, -8388608, 65535, 32767, -32768, 0));
    send_item(fixed_item(pss_pkg::REQ_RESTART, -8388608, 8388607, 0, -32768, 32767, 0));
    write_reg(pss_pkg::CFG_SMOOTH_EN, 1);
    send_item(fixed_item(pss_pkg::REQ_CATCH, 0, 0, 0, 0, 0, 65536));
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 8388607, -8388608, 65535, 32767, -32768, 0));
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, -8388608, 8388607, 0, -32768, 32767, 0));
    send_item(fixed_item(pss_pkg::REQ_CATCH, 0, 0, 0, 0, 0, 131071));
    send_item(fixed_item(pss_pkg::REQ_SPARE, 0, 0, 0, 0, 0, 32768));
    send_item(fixed_item(pss_pkg::REQ_CATCH, 0, 0, 0, 0, 0, 0));
    send_item(fixed_item(pss_pkg::REQ_RESTART, 1000, 2000, 300, 40, -50, 0));
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 1001, 2001, 301, 41, -51, 0));
    write_reg(pss_pkg::CFG_ALPHA, 131071);
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, -5000, 7000, 100, -7, 9, 0));
    write_reg(pss_pkg::CFG_ALPHA, 0);
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 5000, -7000, 60000, 7, -9, 0));
    write_reg(pss_pkg::CFG_DEAD_ZONE, 2560);
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 5100, -7000, 1, 2, 3, 0));
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, -8388608, 8388607, 2, 3, 4, 0));
    write_reg(pss_pkg::CFG_DEAD_ZONE, 8388607);
    send_item(fixed_item(pss_pkg::REQ_SAMPLE, 8388607, -8388608, 2, 3, 4, 0));
    send_item(fixed_item(pss_pkg::REQ_CATCH, 0, 0, 0, 0, 0, 40000));
    write_reg(pss_pkg::CFG_SMOOTH_EN, 0);
    send_item(fixed_item(pss_pkg::REQ_RESTART, 12, 34, 56, 78, 90, 0));
    send_item(fixed_item(pss_pkg::REQ_CATCH, 0, 0, 0, 0, 0, 20000));
  endtask

  task automatic test_random(int count);
    int n, span;
    logic [pss_pkg::REQ_W-1:0] req;
    n = 0;
    while (n < count) begin
      if (n % 100 == 0) begin
        write_reg(pss_pkg::CFG_SMOOTH_EN, ($urandom_range(5) != 0));
        case ($urandom_range(3))
          0: write_reg(pss_pkg::CFG_ALPHA, 0);
          1: write_reg(pss_pkg::CFG_ALPHA, 65536 + $urandom_range(65535));
          default: write_reg(pss_pkg::CFG_ALPHA, $urandom_range(65536));
        endcase
        case ($urandom_range(3))
          0: write_reg(pss_pkg::CFG_DEAD_ZONE, $urandom_range(8388607));
          1: write_reg(pss_pkg::CFG_DEAD_ZONE, $urandom_range(5000));
          default: write_reg(pss_pkg::CFG_DEAD_ZONE, 0);
        endcase
      end
      if (n == 150) drain();
      span = ($urandom_range(7) == 0) ? 0 : 20000;
      case ($urandom_range(9))
        0: req = pss_pkg::REQ_RESTART;
        1, 2: req = pss_pkg::REQ_CATCH;
        3: req = pss_pkg::REQ_SPARE;
        default: req = pss_pkg::REQ_SAMPLE;
      endcase
      send_item(make_item(req, span));
      n++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    smooth_on = 0; pos_weight = 32768; dz_radius = 0;
    sm_x = 0; sm_y = 0; sm_p = 0; sm_tx = 0; sm_ty = 0;
    rw_x = 0; rw_y = 0; rw_p = 0; rw_tx = 0; rw_ty = 0;
    in_stroke = 0;
    @(posedge clk);
    send_idle_pct = 34; recv_idle_pct = 53;
    test_directed();
    test_random(430);
    send_idle_pct = 53; recv_idle_pct = 34;
    test_random(430);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(430);
    drain();
    if (mismatches == 0 && expected_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    wait (timed_out);
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
sv/pss_pkg.sv
sv/pss_datapath.sv
sv/pss_ctrl.sv
sv/pen_stroke_smoother_top.sv
tb/tb_top.sv
